// ----- rtl/vbc_pkg.sv -----
// shared types and register codes for the vector box clip block
package vbc_pkg;

  localparam int CFG_INDEX_W = 8;
  localparam int DATA_W      = 32;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_X_LOW  = 8'd0,
    REG_X_HIGH = 8'd1,
    REG_Y_LOW  = 8'd2,
    REG_Y_HIGH = 8'd3
  } reg_index_t;

  // bounds of one axis
  typedef struct packed {
    logic signed [DATA_W-1:0] low;
    logic [DATA_W-2:0]        high;
  } lim_t;

  // payload carried along the divider stages of one axis
  typedef struct packed {
    logic              clip;
    logic              neg;
    logic              zero;
    logic              sat_one;
    logic [DATA_W-1:0] c_new;
    logic [DATA_W-1:0] o;
    logic [DATA_W-1:0] o_mag;
    logic [DATA_W-1:0] den;
    logic [DATA_W:0]   rem;
  } stage_t;

endpackage

// ----- rtl/vbc_div_step.sv -----
// one registered quotient bit of the restoring ratio divider
module vbc_div_step #(
  parameter int FRAC_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  vbc_pkg::stage_t     in_st,
  input  logic [FRAC_BITS:0]  in_q,
  output logic                out_valid,
  output vbc_pkg::stage_t     out_st,
  output logic [FRAC_BITS:0]  out_q
);

  logic [vbc_pkg::DATA_W:0] rem2;
  logic [vbc_pkg::DATA_W:0] den_ext;
  logic                     take;
  vbc_pkg::stage_t          st_next;

  always_comb begin
    rem2        = {in_st.rem[vbc_pkg::DATA_W-1:0], 1'b0};
    den_ext     = {1'b0, in_st.den};
    take        = (rem2 >= den_ext);
    st_next     = in_st;
    st_next.rem = take ? (rem2 - den_ext) : rem2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_st <= st_next;
      out_q  <= (in_q << 1) | {{FRAC_BITS{1'b0}}, take};
    end
  end

endmodule

// ----- rtl/vbc_axis_clip.sv -----
// clamps one component to its bounds and, when it clamps, scales the other by limit / component
module vbc_axis_clip #(
  parameter int FRAC_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           en,
  input  vbc_pkg::lim_t                  lim,
  input  logic                           in_valid,
  input  logic [vbc_pkg::DATA_W-1:0]     in_c,
  input  logic [vbc_pkg::DATA_W-1:0]     in_o,
  output logic                           out_valid,
  output logic [vbc_pkg::DATA_W-1:0]     out_c,
  output logic [vbc_pkg::DATA_W-1:0]     out_o
);

  localparam int W  = vbc_pkg::DATA_W;
  localparam int PW = W + FRAC_BITS + 1;

  // stage 0: bound test and magnitudes
  logic            s0_valid;
  vbc_pkg::stage_t s0_st;
  vbc_pkg::stage_t s0_next;
  logic [W-1:0]    s0_lim_mag;

  always_comb begin
    logic           hi_hit;
    logic           lo_hit;
    logic [W-1:0]   hi_ext;
    logic [W-1:0]   lim_mag;
    hi_ext  = {1'b0, lim.high};
    hi_hit  = ($signed(in_c) > $signed(hi_ext));
    lo_hit  = !hi_hit && ($signed(in_c) < $signed(lim.low));
    if (hi_hit) begin
      lim_mag = hi_ext;
    end else begin
      lim_mag = lim.low[W-1] ? (~lim.low + 1'b1) : lim.low;
    end
    s0_next         = '0;
    s0_next.clip    = hi_hit | lo_hit;
    s0_next.neg     = (lo_hit & lim.low[W-1]) ^ in_c[W-1] ^ in_o[W-1];
    s0_next.c_new   = hi_hit ? hi_ext : (lo_hit ? lim.low : in_c);
    s0_next.o       = in_o;
    s0_next.o_mag   = in_o[W-1] ? (~in_o + 1'b1) : in_o;
    s0_next.den     = in_c[W-1] ? (~in_c + 1'b1) : in_c;
    s0_next.rem     = {1'b0, lim_mag};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (en) begin
      s0_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_st      <= s0_next;
      s0_lim_mag <= s0_next.rem[W-1:0];
    end
  end

  // stage 1: zero divisor and ratio of one or more
  logic               dv0_valid;
  vbc_pkg::stage_t    dv0_st;
  vbc_pkg::stage_t    dv0_next;
  logic               dv_valid [0:FRAC_BITS];
  vbc_pkg::stage_t    dv_st    [0:FRAC_BITS];
  logic [FRAC_BITS:0] dv_q     [0:FRAC_BITS];

  always_comb begin
    dv0_next         = s0_st;
    dv0_next.zero    = (s0_st.den == '0);
    dv0_next.sat_one = (s0_lim_mag >= s0_st.den);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dv0_valid <= 1'b0;
    end else if (en) begin
      dv0_valid <= s0_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv0_st <= dv0_next;
    end
  end

  assign dv_valid[0] = dv0_valid;
  assign dv_st[0]    = dv0_st;
  assign dv_q[0]     = '0;

  // one quotient bit per stage
  for (genvar k = 0; k < FRAC_BITS; k++) begin : g_div
    vbc_div_step #(
      .FRAC_BITS (FRAC_BITS)
    ) u_step (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (dv_valid[k]),
      .in_st     (dv_st[k]),
      .in_q      (dv_q[k]),
      .out_valid (dv_valid[k+1]),
      .out_st    (dv_st[k+1]),
      .out_q     (dv_q[k+1])
    );
  end

  // multiply stage
  logic               mu_valid;
  logic               mu_clip;
  logic               mu_neg;
  logic [W-1:0]       mu_c_new;
  logic [W-1:0]       mu_o;
  logic [PW-1:0]      mu_prod;
  logic [FRAC_BITS:0] ratio;

  always_comb begin
    if (dv_st[FRAC_BITS].zero) begin
      ratio = '0;
    end else if (dv_st[FRAC_BITS].sat_one) begin
      ratio = {1'b1, {FRAC_BITS{1'b0}}};
    end else begin
      ratio = dv_q[FRAC_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mu_valid <= 1'b0;
    end else if (en) begin
      mu_valid <= dv_valid[FRAC_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mu_clip  <= dv_st[FRAC_BITS].clip;
      mu_neg   <= dv_st[FRAC_BITS].neg;
      mu_c_new <= dv_st[FRAC_BITS].c_new;
      mu_o     <= dv_st[FRAC_BITS].o;
      mu_prod  <= PW'(dv_st[FRAC_BITS].o_mag) * PW'(ratio);
    end
  end

  // truncate, apply sign, saturate
  logic [W:0]   mag_s;
  logic [W-1:0] scaled;

  always_comb begin
    mag_s = mu_prod[FRAC_BITS +: (W + 1)];
    if (mu_neg) begin
      if (mag_s >= {2'b01, {(W-1){1'b0}}}) begin
        scaled = {1'b1, {(W-1){1'b0}}};
      end else begin
        scaled = ~mag_s[W-1:0] + 1'b1;
      end
    end else begin
      if (mag_s > {2'b00, {(W-1){1'b1}}}) begin
        scaled = {1'b0, {(W-1){1'b1}}};
      end else begin
        scaled = mag_s[W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= mu_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_c <= mu_c_new;
      out_o <= mu_clip ? scaled : mu_o;
    end
  end

endmodule

// ----- rtl/vector_box_clip_keep_direction_core.sv -----
// top level: clips a Q16.16 vector to a configured box keeping its direction
//
// usage
//   s_axis carries one vector per item: tdata holds in_x then in_y
//   m_axis returns one clipped vector per item: tdata holds out_x then out_y
//   cfg writes the four bound registers by index (x_low, x_high, y_low,
//   y_high); cfg_ready is always high, write only while the block is idle
// timing
//   x pass then y pass, each FRAC_BITS + 4 register stages: two bound and
//   magnitude stages, one divider stage per quotient bit, one multiply stage
//   and one saturate stage; one item is accepted every cycle while the skid
//   register is empty, since the bit-per-stage ratio divider is fully
//   pipelined
// reset
//   rst clears all valid bits and loads the bounds with -1.0 / +1.0
// stall
//   a skid register holds one finished item when m_axis_tready is low; the
//   pipeline then freezes and s_axis_tready drops until the skid drains
module vector_box_clip_keep_direction_core #(
  parameter int FRAC_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [63:0]                        s_axis_tdata,  // in_x, in_y
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [63:0]                        m_axis_tdata,  // out_x, out_y
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [vbc_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [vbc_pkg::DATA_W-1:0]         cfg_data
);

  localparam int W = vbc_pkg::DATA_W;

  // bound registers
  vbc_pkg::lim_t lim_x;
  vbc_pkg::lim_t lim_y;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      lim_x.low  <= -32'sd65536;
      lim_x.high <= 31'd65536;
      lim_y.low  <= -32'sd65536;
      lim_y.high <= 31'd65536;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        vbc_pkg::REG_X_LOW:  lim_x.low  <= cfg_data;
        vbc_pkg::REG_X_HIGH: lim_x.high <= cfg_data[W-2:0];
        vbc_pkg::REG_Y_LOW:  lim_y.low  <= cfg_data;
        vbc_pkg::REG_Y_HIGH: lim_y.high <= cfg_data[W-2:0];
        default: ;  // writes past the register list are dropped
      endcase
    end
  end

  // pipeline advances whenever the skid register is empty
  logic         skid_full;
  logic [63:0]  skid_data;
  logic         en;

  assign en            = !skid_full;
  assign s_axis_tready = en;

  // x pass: clamp x, scale y
  logic         xp_valid;
  logic [W-1:0] xp_x;
  logic [W-1:0] xp_y;

  vbc_axis_clip #(
    .FRAC_BITS (FRAC_BITS)
  ) u_x_pass (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .lim       (lim_x),
    .in_valid  (s_axis_tvalid),
    .in_c      (s_axis_tdata[31:0]),
    .in_o      (s_axis_tdata[63:32]),
    .out_valid (xp_valid),
    .out_c     (xp_x),
    .out_o     (xp_y)
  );

  // y pass: clamp y, scale x
  logic         yp_valid;
  logic [W-1:0] yp_x;
  logic [W-1:0] yp_y;

  vbc_axis_clip #(
    .FRAC_BITS (FRAC_BITS)
  ) u_y_pass (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .lim       (lim_y),
    .in_valid  (xp_valid),
    .in_c      (xp_y),
    .in_o      (xp_x),
    .out_valid (yp_valid),
    .out_c     (yp_y),
    .out_o     (yp_x)
  );

  // skid: catch the item leaving the pipeline when the receiver stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      skid_full <= 1'b0;
    end else if (skid_full) begin
      if (m_axis_tready) begin
        skid_full <= 1'b0;
      end
    end else if (yp_valid && !m_axis_tready) begin
      skid_full <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_full) begin
      skid_data <= {yp_y, yp_x};
    end
  end

  assign m_axis_tvalid = skid_full | yp_valid;
  assign m_axis_tdata  = skid_full ? skid_data : {yp_y, yp_x};

endmodule

// ----- dv/vbc_clip_checker.sv -----
// checker for the vector box clip block: tracks bounds, predicts clipped vectors, compares
module vbc_clip_checker #(
  parameter int FRAC_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  input  logic                            s_axis_tready,
  input  logic [63:0]                     s_axis_tdata,  // in_x, in_y
  input  logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  input  logic [63:0]                     m_axis_tdata,  // out_x, out_y
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [vbc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [vbc_pkg::DATA_W-1:0]      cfg_data,
  input  logic                            drained,
  output int                              fail_count,
  output int                              pending
);
  import vbc_pkg::*;

  typedef struct packed {
    logic [31:0] y;
    logic [31:0] x;
  } vec_t;

  lim_t x_lim;
  lim_t y_lim;
  vec_t clipped_q[$];
  bit   leftovers_seen = 1'b0;
  int   result_count = 0;

  task automatic report_mismatch(input string what);
    $display("mismatch at result %0d: %s", result_count, what);
    fail_count++;
  endtask

  function automatic longint unsigned magnitude(input longint v);
    return (v < 0) ? longint'(-v) : v;
  endfunction

  // scale o by limit/c, magnitude truncated, sign restored, saturated to 32 bits
  function automatic logic [31:0] scale_by_ratio(input logic signed [31:0] o,
                                                 input longint limit,
                                                 input logic signed [31:0] c);
    longint unsigned den;
    longint unsigned ratio;
    longint unsigned prod;
    longint unsigned one_q;
    bit              neg;
    den   = magnitude(longint'(c));
    one_q = 64'd1 << FRAC_BITS;
    if (den == 0) return '0;
    ratio = (magnitude(limit) << FRAC_BITS) / den;
    if (ratio > one_q) ratio = one_q;
    prod = (magnitude(longint'(o)) * ratio) >> FRAC_BITS;
    neg  = ((limit < 0) != (c < 0)) != (o < 0);
    if (neg) begin
      if (prod >= 64'h8000_0000) return 32'h8000_0000;
      return 32'(-longint'(prod));
    end
    if (prod > 64'h7fff_ffff) prod = 64'h7fff_ffff;
    return prod[31:0];
  endfunction

  function automatic vec_t clip_to_box(input vec_t v, input lim_t xl, input lim_t yl);
    logic signed [31:0] x;
    logic signed [31:0] y;
    longint             xh;
    longint             yh;
    vec_t               r;
    x  = $signed(v.x);
    y  = $signed(v.y);
    xh = longint'({33'd0, xl.high});
    yh = longint'({33'd0, yl.high});
    if (longint'(x) > xh) begin
      y = scale_by_ratio(y, xh, x);
      x = xh[31:0];
    end else if (x < $signed(xl.low)) begin
      y = scale_by_ratio(y, longint'($signed(xl.low)), x);
      x = xl.low;
    end
    if (longint'(y) > yh) begin
      x = scale_by_ratio(x, yh, y);
      y = yh[31:0];
    end else if (y < $signed(yl.low)) begin
      x = scale_by_ratio(x, longint'($signed(yl.low)), y);
      y = yl.low;
    end
    r.x = x;
    r.y = y;
    return r;
  endfunction

  always @(posedge clk) begin
    vec_t want;
    vec_t got;
    if (rst) begin
      x_lim.low  = -32'sd65536;
      x_lim.high = 31'd65536;
      y_lim.low  = -32'sd65536;
      y_lim.high = 31'd65536;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_X_LOW:  x_lim.low  = cfg_data;
          REG_X_HIGH: x_lim.high = cfg_data[30:0];
          REG_Y_LOW:  y_lim.low  = cfg_data;
          REG_Y_HIGH: y_lim.high = cfg_data[30:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready)
        clipped_q.push_back(clip_to_box(s_axis_tdata, x_lim, y_lim));
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        if (clipped_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result %h", got));
        end else begin
          want = clipped_q.pop_front();
          if (got.x !== want.x)
            report_mismatch($sformatf("out_x %h, expected %h", got.x, want.x));
          if (got.y !== want.y)
            report_mismatch($sformatf("out_y %h, expected %h", got.y, want.y));
        end
        result_count++;
      end
      if (drained && !leftovers_seen) begin
        leftovers_seen = 1'b1;
        if (clipped_q.size() != 0)
          report_mismatch($sformatf("%0d results never arrived", clipped_q.size()));
      end
    end
    pending = clipped_q.size();
  end

endmodule

// ----- dv/vector_box_clip_keep_direction_core_tb.sv -----
// testbench top for the vector box clip block: stimulus, bound settings and verdict
module vector_box_clip_keep_direction_core_tb;
  import vbc_pkg::*;

  localparam int FRAC_BITS       = 16;
  localparam int LATENCY         = 2 * (FRAC_BITS + 4);
  localparam int CYCLE_LIMIT     = 400000;
  localparam int HOLD_CYCLES     = 300;
  localparam int RANDOM_PHASES   = 7;
  localparam int ITEMS_PER_PHASE = 250;
  localparam int NUM_DIRECTED    = 16;
  localparam int NUM_TINY        = 6;

  // indexes with no register behind them, writes there must change nothing
  localparam logic [CFG_INDEX_W-1:0] REG_NONE_NEAR = 8'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_NONE_FAR  = 8'hff;

  // directed vectors under the reset box of +-1.0
  localparam logic [31:0] DIR_X [NUM_DIRECTED] = '{
    32'h0000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
    32'h8000_0000, 32'h0001_0000, 32'h0001_0001, 32'hfffe_ffff,
    32'h0000_0000, 32'h0003_0000, 32'hffff_0000, 32'h0002_0000,
    32'hffff_ffff, 32'h8000_0000, 32'h0000_8000, 32'h1234_5678
  };
  localparam logic [31:0] DIR_Y [NUM_DIRECTED] = '{
    32'h0000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000,
    32'h7fff_ffff, 32'h0001_0000, 32'h0000_0000, 32'h0000_0005,
    32'h0002_0000, 32'hfffb_0000, 32'hffff_0000, 32'h0002_0000,
    32'h0000_0001, 32'h0000_0001, 32'h7fff_ffff, 32'hedcb_a987
  };
  // directed vectors under the smallest box, one lsb each way
  localparam logic [31:0] TINY_X [NUM_TINY] = '{
    32'h7fff_ffff, 32'h8000_0000, 32'h0000_0002,
    32'h0000_0001, 32'h0000_0000, 32'h8000_0000
  };
  localparam logic [31:0] TINY_Y [NUM_TINY] = '{
    32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000,
    32'hffff_ffff, 32'h7fff_ffff, 32'h0000_0000
  };

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [63:0]            s_axis_tdata = '0;   // in_x, in_y
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [63:0]            m_axis_tdata;        // out_x, out_y
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [DATA_W-1:0]      cfg_data = '0;
  logic                   drained = 1'b0;

  int fail_count;
  int pending;
  int cycle_count = 0;

  // idle percentages of the current phase
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  // long receiver hold-off, requested by stimulus and served by the receiver
  int hold_req  = 0;
  int hold_done = 0;
  int hold_left = 0;

  // stimulus copy of the box, only used to aim vectors near the edges
  logic [31:0] box_xl = -32'sd65536;
  logic [30:0] box_xh = 31'd65536;
  logic [31:0] box_yl = -32'sd65536;
  logic [30:0] box_yh = 31'd65536;

  always #5 clk = ~clk;

  vector_box_clip_keep_direction_core #(
    .FRAC_BITS(FRAC_BITS)
  ) u_dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  vbc_clip_checker #(
    .FRAC_BITS(FRAC_BITS)
  ) u_clip_check (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .drained      (drained),
    .fail_count   (fail_count),
    .pending      (pending)
  );

  // watchdog on the whole run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // receiver: random stalls, or a long hold-off when one is requested
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (hold_req != hold_done) begin
      hold_done++;
      hold_left = HOLD_CYCLES - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // one register write, valid dropped again after acceptance
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // load a whole box, plus a stray write to an unused index
  task automatic load_box(input logic [31:0] xl, input logic [30:0] xh,
                          input logic [31:0] yl, input logic [30:0] yh);
    write_reg(REG_X_LOW, xl);
    write_reg(REG_X_HIGH, {1'b0, xh});
    write_reg(REG_Y_LOW, yl);
    write_reg(REG_Y_HIGH, {1'b0, yh});
    write_reg(($urandom_range(1) != 0) ? REG_NONE_NEAR : REG_NONE_FAR, $urandom);
    box_xl = xl;
    box_xh = xh;
    box_yl = yl;
    box_yh = yh;
  endtask

  // offer one vector, with random idle cycles ahead of it; returns once accepted
  task automatic send_vector(input logic [31:0] vx, input logic [31:0] vy);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {vy, vx};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  // stop offering and wait for every expected result
  task automatic settle();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // lower bound, always negative
  function automatic logic [31:0] rand_low();
    case ($urandom_range(2))
      0:       return {1'b1, 31'($urandom)};
      1:       return -32'($urandom_range(32'h0010_0000, 1));
      default: return -(32'($urandom_range(8, 1)) << FRAC_BITS);
    endcase
  endfunction

  // upper bound, always positive
  function automatic logic [30:0] rand_high();
    case ($urandom_range(2))
      0:       return 31'($urandom_range(32'h7fff_ffff, 1));
      1:       return 31'($urandom_range(32'h0010_0000, 1));
      default: return 31'($urandom_range(8, 1) << FRAC_BITS);
    endcase
  endfunction

  // one component: full random, near a bound, a multiple of a bound, small or extreme
  function automatic logic [31:0] pick_comp(input logic [31:0] lo, input logic [30:0] hi);
    longint v;
    case ($urandom_range(9))
      0, 1: v = longint'($signed($urandom));
      2, 3: v = longint'({33'd0, hi}) + longint'($urandom_range(8)) - 4;
      4, 5: v = longint'($signed(lo)) + longint'($urandom_range(8)) - 4;
      6:    v = longint'($signed($urandom) >>> $urandom_range(31));
      7: begin
        case ($urandom_range(5))
          0:       v = -64'sd2147483648;
          1:       v = 64'sd2147483647;
          2:       v = 0;
          3:       v = 1;
          4:       v = -1;
          default: v = 64'sd65536;
        endcase
      end
      8:       v = longint'({33'd0, hi}) * longint'($urandom_range(8, 2));
      default: v = longint'($signed(lo)) * longint'($urandom_range(8, 2));
    endcase
    // keep inside the 32 bit signed range
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return v[31:0];
  endfunction

  initial begin
    int mode;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed part under the reset box
    for (int i = 0; i < NUM_DIRECTED; i++) send_vector(DIR_X[i], DIR_Y[i]);
    settle();

    // directed part under the smallest box
    load_box(32'hffff_ffff, 31'd1, 32'hffff_ffff, 31'd1);
    for (int i = 0; i < NUM_TINY; i++) send_vector(TINY_X[i], TINY_Y[i]);
    settle();

    // random phases, each with its own box and idle mode
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0:       load_box(32'h8000_0000, 31'h7fff_ffff, 32'h8000_0000, 31'h7fff_ffff);
        1:       load_box(32'hffff_ffff, 31'd1, 32'hffff_ffff, 31'd1);
        2:       load_box(32'h8000_0000, 31'd1, 32'hffff_ffff, 31'h7fff_ffff);
        3:       load_box(-32'sd65536, 31'd65536, -32'sd65536, 31'd65536);
        default: load_box(rand_low(), rand_high(), rand_low(), rand_high());
      endcase
      mode = p % 4;
      case (mode)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
          // a long receiver hold-off while vectors keep coming fills the pipe
          hold_req++;
        end
        1: begin
          send_idle_pct  = 85;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 85;
        end
        default: begin
          send_idle_pct  = 8;
          recv_stall_pct = 8;
        end
      endcase
      for (int i = 0; i < ITEMS_PER_PHASE; i++)
        send_vector(pick_comp(box_xl, box_xh), pick_comp(box_yl, box_yh));
      settle();
    end

    // watch for stray results a little longer, then close out leftovers
    repeat (LATENCY) @(negedge clk);
    drained = 1'b1;
    repeat (2) @(negedge clk);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/vbc_pkg.sv
rtl/vbc_div_step.sv
rtl/vbc_axis_clip.sv
rtl/vector_box_clip_keep_direction_core.sv
dv/vbc_clip_checker.sv
dv/vector_box_clip_keep_direction_core_tb.sv
